// ===== rtl/qph_pkg.sv =====
// Shared constants, codes and types of the quadratic-probe hash table.
package qph_pkg;

	localparam int TABLE_SLOTS = 101;
	localparam int PROBE_LIMIT = 20;
	localparam int KEY_CHARS   = 15;
	localparam int HASH_MUL    = 19;
	localparam int PROBE_LIN   = 23;

	localparam int KEY_W  = 120;
	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int IDX_W  = (SLOT_W + 1 > 7) ? SLOT_W + 1 : 7;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int JW     = $clog2(PROBE_LIMIT + 1);

	// Home slot arithmetic: weighted byte sum, times HASH_MUL, reduced by reciprocal.
	localparam int SUM_MAX = 255 * KEY_CHARS * (KEY_CHARS + 1) / 2;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int X_MAX   = HASH_MUL * SUM_MAX;
	localparam int XW      = ($clog2(X_MAX + 1) > SLOT_W + 1) ? $clog2(X_MAX + 1) : SLOT_W + 1;
	localparam int HK      = XW + SLOT_W;
	localparam longint unsigned RECIP = ((64'd1 << HK) + TABLE_SLOTS - 1) / TABLE_SLOTS;
	localparam longint unsigned MUL_RECIP = RECIP * HASH_MUL;
	localparam int RW = $clog2(MUL_RECIP + 1);
	localparam int PW = SUM_W + RW;

	// Probe step j -> j+1 adds 2j + 1 + PROBE_LIN; keep it reduced mod TABLE_SLOTS.
	localparam int D0     = (PROBE_LIN + 1) % TABLE_SLOTS;
	localparam int D_STEP = 2 % TABLE_SLOTS;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_CHARS);

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_DEL   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
	} qph_home_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              ins_en;
		logic              del_en;
		logic [SLOT_W-1:0] wr_addr;
		logic              clr_all;
	} qph_cmd_t;

endpackage

// ===== rtl/qph_hash.sv =====
// Three-stage pipeline computing the home slot of a key.
module qph_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [qph_pkg::KEY_W-1:0] key,
	output qph_pkg::qph_home_t        home
);
	import qph_pkg::*;

	logic [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]  sum_s1;
	logic [PW-1:0]     prod;
	logic [XW-1:0]     q_s2;
	logic [XW-1:0]     x_s2;
	logic [XW-1:0]     qn;
	logic [XW-1:0]     rr;
	logic [SLOT_W-1:0] home_s3;
	logic              v_s1, v_s2, v_s3;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < 15; i++) begin
			sum_c = sum_c + SUM_W'(key[8*i +: 8]) * SUM_W'(i + 1);
		end
	end

	assign prod = PW'(sum_s1) * PW'(MUL_RECIP);
	assign qn   = q_s2 * XW'(TABLE_SLOTS);
	assign rr   = x_s2 - qn;

	always_ff @(posedge clk) begin
		sum_s1  <= sum_c;
		q_s2    <= XW'(prod >> HK);
		x_s2    <= XW'(sum_s1) * XW'(HASH_MUL);
		// quotient is exact; the compare only guards the last reduction
		home_s3 <= (rr >= XW'(TABLE_SLOTS)) ? SLOT_W'(rr - XW'(TABLE_SLOTS)) : SLOT_W'(rr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign home.valid = v_s3;
	assign home.slot  = home_s3;

endmodule

// ===== rtl/qph_store.sv =====
// Slot storage: key memory, per-slot valid bits and the live count.
module qph_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  qph_pkg::qph_cmd_t          cmd,
	input  logic [qph_pkg::KEY_W-1:0]  wr_key,
	output logic [qph_pkg::KEY_W-1:0]  rd_key,
	output logic                       rd_valid,
	output logic [qph_pkg::CNT_W-1:0]  count
);
	import qph_pkg::*;

	logic [KEY_W-1:0]       key_mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [KEY_W-1:0]       rd_key_q;
	logic                   rd_valid_q;
	logic [CNT_W-1:0]       count_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			key_mem[cmd.wr_addr] <= wr_key;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_addr];
			end
			if (cmd.clr_all) begin
				valid_q <= '0;
				count_q <= '0;
			end else if (cmd.ins_en) begin
				valid_q[cmd.wr_addr] <= 1'b1;
				count_q              <= count_q + CNT_W'(1);
			end else if (cmd.del_en) begin
				valid_q[cmd.wr_addr] <= 1'b0;
				count_q              <= count_q - CNT_W'(1);
			end
		end
	end

	assign rd_key   = rd_key_q;
	assign rd_valid = rd_valid_q;
	assign count    = count_q;

endmodule

// ===== rtl/quadratic_probe_hash_table.sv =====
// Top level: command sequencer of the quadratic-probe hash table.
// Usage: drive mode, key_lo, key_hi and slot_index with start high; the command
// is taken at a rising edge where start is high and busy is low. busy stays high
// until the command's single result has been launched.
// The result shows on status, slot, live_count, slot_used, slot_key_lo and
// slot_key_hi for exactly one cycle with done high; the receiver cannot stall
// it, so it must take every beat. A new command may be taken in the cycle the
// result shows.
// Steps from accept to done:
//   clear: done shows in the cycle after accept (all valid bits drop at once).
//   read slot: one key memory read.
//   add / delete: hashing, then P probes, P the number of probes, 1 to 20.
//   The key passes the hash pipeline; then one probe read is issued per cycle
//   and each probe is judged in the cycle its read data returns.
// Items are taken one at a time; the probe loop on the key memory port sets
// the rate.
// Reset: all slots empty, count zero, no result pending. Key memory content
// is not cleared; empty slots are never read for their keys.
module quadratic_probe_hash_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   mode,
	input  logic [63:0]  key_lo,
	input  logic [55:0]  key_hi,
	input  logic [6:0]   slot_index,
	output logic         done,
	output logic [1:0]   status,
	output logic [6:0]   slot,
	output logic [6:0]   live_count,
	output logic         slot_used,
	output logic [63:0]  slot_key_lo,
	output logic [55:0]  slot_key_hi
);
	import qph_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_RDATA = 5'b00100,
		S_HASH  = 5'b01000,
		S_PROBE = 5'b10000
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [6:0]        idx_q;
	logic              go_q;

	logic [SLOT_W-1:0] p_q;
	logic [SLOT_W-1:0] d_q;
	logic [JW-1:0]     iss_q;
	logic              pend_q;
	logic [SLOT_W-1:0] rslot_q;
	logic              last_q;

	logic              done_q;
	status_t           status_q;
	logic [6:0]        slot_q;
	logic              used_q;
	logic [KEY_W-1:0]  rkey_q;

	qph_home_t         home;
	qph_cmd_t          cmd;
	logic [KEY_W-1:0]  rd_key;
	logic              rd_valid;
	logic [CNT_W-1:0]  count;

	logic              accept;
	logic              issuing;
	logic              hit;
	logic              in_range;
	logic [SLOT_W:0]   p_sum;
	logic [SLOT_W:0]   d_sum;
	logic [SLOT_W-1:0] p_next;
	logic [SLOT_W-1:0] d_next;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign issuing  = (state_q == S_PROBE) && (iss_q < JW'(PROBE_LIMIT));
	assign hit      = rd_valid && (rd_key == key_q);
	assign in_range = IDX_W'(idx_q) < IDX_W'(TABLE_SLOTS);

	assign p_sum  = (SLOT_W + 1)'(p_q) + (SLOT_W + 1)'(d_q);
	assign d_sum  = (SLOT_W + 1)'(d_q) + (SLOT_W + 1)'(D_STEP);
	assign p_next = (p_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) ?
		SLOT_W'(p_sum - (SLOT_W + 1)'(TABLE_SLOTS)) : SLOT_W'(p_sum);
	assign d_next = (d_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) ?
		SLOT_W'(d_sum - (SLOT_W + 1)'(TABLE_SLOTS)) : SLOT_W'(d_sum);

	qph_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.key    (key_q),
		.home   (home)
	);

	qph_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_key   (key_q),
		.rd_key   (rd_key),
		.rd_valid (rd_valid),
		.count    (count)
	);

	always_comb begin
		cmd         = '0;
		cmd.wr_addr = rslot_q;
		cmd.rd_addr = p_q;
		case (state_q)
			S_IDLE: begin
				cmd.clr_all = start && (mode_t'(mode) == MODE_CLEAR);
			end
			S_READ: begin
				cmd.rd_en   = in_range;
				cmd.rd_addr = SLOT_W'(idx_q);
			end
			S_PROBE: begin
				cmd.rd_en = issuing;
				if (pend_q) begin
					cmd.ins_en = (mode_q == MODE_ADD) && !rd_valid;
					cmd.del_en = (mode_q == MODE_DEL) && hit;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			key_q  <= {key_hi, key_lo} & KEY_MASK;
			idx_q  <= slot_index;
		end
		if (state_q == S_HASH) begin
			p_q <= home.slot;
			d_q <= SLOT_W'(D0);
		end else if (issuing) begin
			p_q <= p_next;
			d_q <= d_next;
		end
		if (issuing) begin
			rslot_q <= p_q;
			last_q  <= (iss_q == JW'(PROBE_LIMIT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			go_q     <= 1'b0;
			iss_q    <= '0;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
			slot_q   <= '0;
			used_q   <= 1'b0;
			rkey_q   <= '0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (mode_t'(mode))
							MODE_CLEAR: begin
								done_q   <= 1'b1;
								status_q <= ST_DONE;
								slot_q   <= '0;
								used_q   <= 1'b0;
								rkey_q   <= '0;
							end
							MODE_READ: begin
								state_q <= S_READ;
							end
							default: begin
								go_q    <= 1'b1;
								state_q <= S_HASH;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					done_q   <= 1'b1;
					status_q <= in_range ? ST_DONE : ST_MISS;
					slot_q   <= idx_q;
					used_q   <= in_range && rd_valid;
					rkey_q   <= (in_range && rd_valid) ? rd_key : '0;
					state_q  <= S_IDLE;
				end
				S_HASH: begin
					if (home.valid) begin
						iss_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (issuing) begin
						iss_q <= iss_q + JW'(1);
					end
					pend_q <= issuing;
					if (pend_q) begin
						used_q <= 1'b0;
						rkey_q <= '0;
						// judge the probe whose read returned this cycle
						if (mode_q == MODE_ADD) begin
							if (!rd_valid || hit) begin
								done_q   <= 1'b1;
								status_q <= rd_valid ? ST_MISS : ST_DONE;
								slot_q   <= 7'(rslot_q);
								state_q  <= S_IDLE;
							end else if (last_q) begin
								done_q   <= 1'b1;
								status_q <= ST_FULL;
								slot_q   <= '0;
								state_q  <= S_IDLE;
							end
						end else begin
							if (hit) begin
								done_q   <= 1'b1;
								status_q <= ST_DONE;
								slot_q   <= 7'(rslot_q);
								state_q  <= S_IDLE;
							end else if (last_q) begin
								done_q   <= 1'b1;
								status_q <= ST_MISS;
								slot_q   <= '0;
								state_q  <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign live_count  = 7'(count);
	assign slot_used   = used_q;
	assign slot_key_lo = rkey_q[63:0];
	assign slot_key_hi = rkey_q[119:64];

endmodule
